// ===== design/erv_pkg.sv =====
// shared constants and types for the euler vector rotation block
`default_nettype none
package erv_pkg;

   // angle and trig formats
   localparam int ANGLE_BITS     = 16;
   localparam int TRIG_FRAC_BITS = 15;
   localparam int TRIG_W         = TRIG_FRAC_BITS + 2;
   localparam int TRIG_SHIFT     = 30 - TRIG_FRAC_BITS;
   localparam int VEC_W          = 32;

   // taylor series, one cell per term
   localparam int NUM_TERMS = 9;
   localparam int CELL_LAT  = 3;
   localparam int TRIG_LAT  = 2 + CELL_LAT * NUM_TERMS + 1;
   localparam int ROT_LAT   = 2;
   localparam int TOTAL_LAT = TRIG_LAT + 3 * ROT_LAT;

   // fixed point constants in Q2.30
   localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
   localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
   localparam logic [29:0] HALF_Q30    = 30'h2000_0000;

   // divisors and ceil(2^33 / d) reciprocals of each term
   localparam logic [8:0] SIN_DIV [NUM_TERMS] = '{
      9'd6, 9'd20, 9'd42, 9'd72, 9'd110, 9'd156, 9'd210, 9'd272, 9'd1};
   localparam logic [32:0] SIN_REC [NUM_TERMS] = '{
      33'd1431655766, 33'd429496730, 33'd204522253, 33'd119304648,
      33'd78090315, 33'd55063684, 33'd40904451, 33'd31580642, 33'd0};
   localparam logic [8:0] COS_DIV [NUM_TERMS] = '{
      9'd2, 9'd12, 9'd30, 9'd56, 9'd90, 9'd132, 9'd182, 9'd240, 9'd306};
   localparam logic [32:0] COS_REC [NUM_TERMS] = '{
      33'd4294967296, 33'd715827883, 33'd286331154, 33'd153391690,
      33'd95443718, 33'd65075263, 33'd47197443, 33'd35791395, 33'd28071682};

   // running series state handed from cell to cell
   typedef struct packed {
      logic [30:0] s_t;
      logic [33:0] s_sum;
      logic [30:0] c_t;
      logic [33:0] c_sum;
      logic [31:0] x2;
      logic [1:0]  quad;
   } erv_term_type;

   // per cell constants
   typedef struct packed {
      logic [8:0]  s_div;
      logic [32:0] s_rec;
      logic [8:0]  c_div;
      logic [32:0] c_rec;
      logic        s_on;
      logic        neg;
   } erv_cell_cfg_type;

   // quadrant codes
   localparam logic [1:0] QUAD_0 = 2'd0;
   localparam logic [1:0] QUAD_1 = 2'd1;
   localparam logic [1:0] QUAD_2 = 2'd2;
   localparam logic [1:0] QUAD_3 = 2'd3;

endpackage
`default_nettype wire

// ===== design/euler_rotate_vector3_top.sv =====
// euler rotation of a 3d vector: z, then y, then x, Q16.16 in and out
//
// Input items arrive on req_valid / req_stall with the vector and three
// binary angles (65536 per turn); results leave on rsp_valid / rsp_stall.
// An item is taken when valid is high and stall is low.
// Each angle runs through its own row of nine taylor term cells (three
// register stages per cell) that produce sine and cosine; the three
// planar rotations follow, two stages each. One item is accepted every
// cycle while the pipeline is not held.
// The whole pipeline holds only while a result sits on the output and
// rsp_stall is high; otherwise items keep entering, also while a result
// waits to be taken in that same cycle.
// Reset clears the valid bits of the pipeline; no result is shown until
// an item has gone through. A stalled result holds its value.
`default_nettype none
module euler_rotate_vector3_top (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output      logic                               req_stall,
   input  wire logic signed [erv_pkg::VEC_W-1:0]   req_vec_x,
   input  wire logic signed [erv_pkg::VEC_W-1:0]   req_vec_y,
   input  wire logic signed [erv_pkg::VEC_W-1:0]   req_vec_z,
   input  wire logic [erv_pkg::ANGLE_BITS-1:0]     req_angle_x,
   input  wire logic [erv_pkg::ANGLE_BITS-1:0]     req_angle_y,
   input  wire logic [erv_pkg::ANGLE_BITS-1:0]     req_angle_z,
   output      logic                               rsp_valid,
   input  wire logic                               rsp_stall,
   output      logic signed [erv_pkg::VEC_W-1:0]   rsp_out_x,
   output      logic signed [erv_pkg::VEC_W-1:0]   rsp_out_y,
   output      logic signed [erv_pkg::VEC_W-1:0]   rsp_out_z
);
   import erv_pkg::*;

   logic en;
   logic [TOTAL_LAT-1:0] valid_ff;
   logic signed [VEC_W-1:0] vx_ff [TRIG_LAT], vy_ff [TRIG_LAT], vz_ff [TRIG_LAT];
   logic signed [TRIG_W-1:0] sz, cz, sy, cy, sx, cx;
   logic signed [TRIG_W-1:0] sy_ff [ROT_LAT], cy_ff [ROT_LAT];
   logic signed [TRIG_W-1:0] sx_ff [2*ROT_LAT], cx_ff [2*ROT_LAT];
   logic signed [VEC_W-1:0] z1_ff [ROT_LAT], y2_ff [ROT_LAT], x3_ff [ROT_LAT];
   logic signed [VEC_W-1:0] x1, y1, z2, x2, y3, z3;

   // pipeline advances unless a held result is stalled
   assign en        = !(valid_ff[TOTAL_LAT-1] && rsp_stall);
   assign req_stall = !en;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[TOTAL_LAT-2:0], req_valid};
      end
   end

   // vector and trig delay lines
   always_ff @(posedge clock) begin
      if (en) begin
         vx_ff[0] <= req_vec_x;
         vy_ff[0] <= req_vec_y;
         vz_ff[0] <= req_vec_z;
         for (int i = 1; i < TRIG_LAT; i++) begin
            vx_ff[i] <= vx_ff[i-1];
            vy_ff[i] <= vy_ff[i-1];
            vz_ff[i] <= vz_ff[i-1];
         end
         sy_ff[0] <= sy;
         cy_ff[0] <= cy;
         for (int i = 1; i < ROT_LAT; i++) begin
            sy_ff[i] <= sy_ff[i-1];
            cy_ff[i] <= cy_ff[i-1];
         end
         sx_ff[0] <= sx;
         cx_ff[0] <= cx;
         for (int i = 1; i < 2*ROT_LAT; i++) begin
            sx_ff[i] <= sx_ff[i-1];
            cx_ff[i] <= cx_ff[i-1];
         end
         z1_ff[0] <= vz_ff[TRIG_LAT-1];
         y2_ff[0] <= y1;
         x3_ff[0] <= x2;
         for (int i = 1; i < ROT_LAT; i++) begin
            z1_ff[i] <= z1_ff[i-1];
            y2_ff[i] <= y2_ff[i-1];
            x3_ff[i] <= x3_ff[i-1];
         end
      end
   end

   // trig units
   erv_trig u_trig_z (.clock(clock), .en(en), .angle(req_angle_z), .sin_out(sz), .cos_out(cz));
   erv_trig u_trig_y (.clock(clock), .en(en), .angle(req_angle_y), .sin_out(sy), .cos_out(cy));
   erv_trig u_trig_x (.clock(clock), .en(en), .angle(req_angle_x), .sin_out(sx), .cos_out(cx));

   // rotation about z: (x, y)
   erv_rot_cell u_rot_z (
      .clock(clock), .en(en),
      .u_in(vx_ff[TRIG_LAT-1]), .v_in(vy_ff[TRIG_LAT-1]),
      .sin_in(sz), .cos_in(cz), .u_out(x1), .v_out(y1)
   );

   // rotation about y: (z, x)
   erv_rot_cell u_rot_y (
      .clock(clock), .en(en),
      .u_in(z1_ff[ROT_LAT-1]), .v_in(x1),
      .sin_in(sy_ff[ROT_LAT-1]), .cos_in(cy_ff[ROT_LAT-1]), .u_out(z2), .v_out(x2)
   );

   // rotation about x: (y, z)
   erv_rot_cell u_rot_x (
      .clock(clock), .en(en),
      .u_in(y2_ff[ROT_LAT-1]), .v_in(z2),
      .sin_in(sx_ff[2*ROT_LAT-1]), .cos_in(cx_ff[2*ROT_LAT-1]), .u_out(y3), .v_out(z3)
   );

   assign rsp_valid = valid_ff[TOTAL_LAT-1];
   assign rsp_out_x = x3_ff[ROT_LAT-1];
   assign rsp_out_y = y3;
   assign rsp_out_z = z3;

endmodule
`default_nettype wire

// ===== design/erv_term_cell.sv =====
// one taylor term cell: multiply by x^2, divide by a constant, accumulate
`default_nettype none
module erv_term_cell (
   input  wire logic                     clock,
   input  wire logic                     en,
   input  wire erv_pkg::erv_cell_cfg_type cfg,
   input  wire erv_pkg::erv_term_type     term_in,
   output      erv_pkg::erv_term_type     term_out
);
   import erv_pkg::*;

   erv_term_type t1_ff, t2_ff, t3_ff;
   logic [62:0]  s_prod_ff, c_prod_ff;
   logic [62:0]  s_prod_in, c_prod_in;
   logic [33:0]  s_ad_ff, c_ad_ff, s_ad_in, c_ad_in;
   logic [66:0]  s_est_ff, c_est_ff, s_est_in, c_est_in;
   logic [33:0]  s_q, c_q;
   logic [42:0]  s_qd, c_qd;
   erv_term_type t3_in;

   // stage 1: term times x^2
   always_comb begin
      s_prod_in = 63'(term_in.s_t) * 63'(term_in.x2);
      c_prod_in = 63'(term_in.c_t) * 63'(term_in.x2);
   end

   // stage 2: round to Q30, add half divisor, multiply by reciprocal
   always_comb begin
      s_ad_in  = 34'((s_prod_ff + 63'(HALF_Q30)) >> 30) + 34'(cfg.s_div >> 1);
      c_ad_in  = 34'((c_prod_ff + 63'(HALF_Q30)) >> 30) + 34'(cfg.c_div >> 1);
      s_est_in = 67'(s_ad_in) * 67'(cfg.s_rec);
      c_est_in = 67'(c_ad_in) * 67'(cfg.c_rec);
   end

   // stage 3: fix the quotient estimate and accumulate
   always_comb begin
      s_q   = 34'(s_est_ff >> 33);
      c_q   = 34'(c_est_ff >> 33);
      s_qd  = 43'(s_q) * 43'(cfg.s_div);
      c_qd  = 43'(c_q) * 43'(cfg.c_div);
      t3_in = t2_ff;
      if (s_qd > 43'(s_ad_ff)) begin
         s_q = s_q - 34'd1;
      end
      if (c_qd > 43'(c_ad_ff)) begin
         c_q = c_q - 34'd1;
      end
      if (cfg.s_on) begin
         t3_in.s_t   = 31'(s_q);
         t3_in.s_sum = cfg.neg ? t2_ff.s_sum - s_q : t2_ff.s_sum + s_q;
      end
      t3_in.c_t   = 31'(c_q);
      t3_in.c_sum = cfg.neg ? t2_ff.c_sum - c_q : t2_ff.c_sum + c_q;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t1_ff     <= term_in;
         s_prod_ff <= s_prod_in;
         c_prod_ff <= c_prod_in;
         t2_ff     <= t1_ff;
         s_ad_ff   <= s_ad_in;
         c_ad_ff   <= c_ad_in;
         s_est_ff  <= s_est_in;
         c_est_ff  <= c_est_in;
         t3_ff     <= t3_in;
      end
   end

   assign term_out = t3_ff;

endmodule
`default_nettype wire

// ===== design/erv_trig.sv =====
// sine and cosine of a binary angle through a chain of taylor term cells
`default_nettype none
module erv_trig (
   input  wire logic                               clock,
   input  wire logic                               en,
   input  wire logic [erv_pkg::ANGLE_BITS-1:0]     angle,
   output      logic signed [erv_pkg::TRIG_W-1:0]  sin_out,
   output      logic signed [erv_pkg::TRIG_W-1:0]  cos_out
);
   import erv_pkg::*;

   localparam logic [33:0] ONE_SUM   = 34'(ONE_Q30);
   localparam logic [30:0] TRIG_RND  =
      (TRIG_SHIFT > 0) ? 31'(64'd1 << (TRIG_SHIFT - 1)) : 31'd0;

   logic [29:0]  r;
   logic [60:0]  xp_ff, xp_in;
   logic [1:0]   q1_ff, q2_ff;
   logic [30:0]  x_ff, x_in;
   logic [61:0]  xxp_ff, xxp_in;
   erv_term_type chain [NUM_TERMS+1];
   erv_cell_cfg_type cfgs [NUM_TERMS];
   logic [30:0]  s_cl, c_cl;
   logic [TRIG_W-2:0] s_mag, c_mag;
   logic signed [TRIG_W-1:0] s_v, c_v, sin_in, cos_in, sin_ff, cos_ff;

   // front: radians in Q2.30, then its square
   always_comb begin
      r      = 30'(32'(angle) << (32 - ANGLE_BITS));
      xp_in  = 61'(r) * 61'(HALF_PI_Q30);
      x_in   = 31'((xp_ff + 61'(HALF_Q30)) >> 30);
      xxp_in = 62'(x_in) * 62'(x_in);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         xp_ff  <= xp_in;
         q1_ff  <= angle[ANGLE_BITS-1 -: 2];
         x_ff   <= x_in;
         xxp_ff <= xxp_in;
         q2_ff  <= q1_ff;
      end
   end

   // series start values
   always_comb begin
      chain[0].s_t   = x_ff;
      chain[0].s_sum = 34'(x_ff);
      chain[0].c_t   = ONE_Q30;
      chain[0].c_sum = ONE_SUM;
      chain[0].x2    = 32'((xxp_ff + 62'(HALF_Q30)) >> 30);
      chain[0].quad  = q2_ff;
   end

   // row of term cells
   for (genvar k = 0; k < NUM_TERMS; k++) begin : g_cell
      assign cfgs[k] = '{s_div: SIN_DIV[k], s_rec: SIN_REC[k],
                         c_div: COS_DIV[k], c_rec: COS_REC[k],
                         s_on: (k < NUM_TERMS - 1), neg: (k % 2 == 0)};
      erv_term_cell u_cell (
         .clock    (clock),
         .en       (en),
         .cfg      (cfgs[k]),
         .term_in  (chain[k]),
         .term_out (chain[k+1])
      );
   end

   // clamp to [0, 1], reduce to trig format, fold quadrant
   always_comb begin
      s_cl = $signed(chain[NUM_TERMS].s_sum) < 0 ? 31'd0 :
             (chain[NUM_TERMS].s_sum > ONE_SUM ? ONE_Q30 : 31'(chain[NUM_TERMS].s_sum));
      c_cl = $signed(chain[NUM_TERMS].c_sum) < 0 ? 31'd0 :
             (chain[NUM_TERMS].c_sum > ONE_SUM ? ONE_Q30 : 31'(chain[NUM_TERMS].c_sum));
      s_mag = (TRIG_W-1)'((s_cl + TRIG_RND) >> TRIG_SHIFT);
      c_mag = (TRIG_W-1)'((c_cl + TRIG_RND) >> TRIG_SHIFT);
      s_v   = $signed({1'b0, s_mag});
      c_v   = $signed({1'b0, c_mag});
      case (chain[NUM_TERMS].quad)
         QUAD_0: begin
            sin_in = s_v;
            cos_in = c_v;
         end
         QUAD_1: begin
            sin_in = c_v;
            cos_in = -s_v;
         end
         QUAD_2: begin
            sin_in = -s_v;
            cos_in = -c_v;
         end
         default: begin
            sin_in = -c_v;
            cos_in = s_v;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sin_ff <= sin_in;
         cos_ff <= cos_in;
      end
   end

   assign sin_out = sin_ff;
   assign cos_out = cos_ff;

endmodule
`default_nettype wire

// ===== design/erv_rot_cell.sv =====
// planar rotation (u, v) -> (u c - v s, u s + v c) with rounding and saturation
`default_nettype none
module erv_rot_cell (
   input  wire logic                              clock,
   input  wire logic                              en,
   input  wire logic signed [erv_pkg::VEC_W-1:0]  u_in,
   input  wire logic signed [erv_pkg::VEC_W-1:0]  v_in,
   input  wire logic signed [erv_pkg::TRIG_W-1:0] sin_in,
   input  wire logic signed [erv_pkg::TRIG_W-1:0] cos_in,
   output      logic signed [erv_pkg::VEC_W-1:0]  u_out,
   output      logic signed [erv_pkg::VEC_W-1:0]  v_out
);
   import erv_pkg::*;

   localparam int PW = VEC_W + TRIG_W;
   localparam int SW = PW + 1;
   localparam logic signed [SW-1:0] RND =
      (TRIG_FRAC_BITS > 0) ? SW'(64'd1 << (TRIG_FRAC_BITS - 1)) : SW'(0);
   localparam logic signed [SW-1:0] MAX_V = SW'(64'h7FFF_FFFF);
   localparam logic signed [SW-1:0] MIN_V = -MAX_V - SW'(1);

   logic signed [PW-1:0] uc_ff, vs_ff, us_ff, vc_ff;
   logic signed [SW-1:0] a_sum, b_sum, a_sh, b_sh;
   logic signed [VEC_W-1:0] u_in_v, v_in_v, u_ff, v_ff;

   // round, floor shift, saturate
   always_comb begin
      a_sum  = SW'(uc_ff) - SW'(vs_ff) + RND;
      b_sum  = SW'(us_ff) + SW'(vc_ff) + RND;
      a_sh   = a_sum >>> TRIG_FRAC_BITS;
      b_sh   = b_sum >>> TRIG_FRAC_BITS;
      u_in_v = a_sh > MAX_V ? VEC_W'(MAX_V) : (a_sh < MIN_V ? VEC_W'(MIN_V) : VEC_W'(a_sh));
      v_in_v = b_sh > MAX_V ? VEC_W'(MAX_V) : (b_sh < MIN_V ? VEC_W'(MIN_V) : VEC_W'(b_sh));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         uc_ff <= PW'(u_in) * PW'(cos_in);
         vs_ff <= PW'(v_in) * PW'(sin_in);
         us_ff <= PW'(u_in) * PW'(sin_in);
         vc_ff <= PW'(v_in) * PW'(cos_in);
         u_ff  <= u_in_v;
         v_ff  <= v_in_v;
      end
   end

   assign u_out = u_ff;
   assign v_out = v_ff;

endmodule
`default_nettype wire
